// ===== rtl/core/pifo_pkg.sv =====
// Package for the PIFO queue with priority drop.
// Holds shared constants, opcodes, status codes, controller states and command/status structs.
package pifo_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int TAG_BITS_DEF    = 16;
  localparam int MAX_RETRIES_DEF = 15;
  localparam int RANK_W          = 32;
  localparam int STAMP_W         = 32;
  localparam int OCC_W           = 7;
  localparam int RC_W            = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_PUSHED  = 3'd0;
  localparam logic [2:0] ST_DROPPED = 3'd1;
  localparam logic [2:0] ST_POPPED  = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;
  localparam logic [2:0] ST_NOTFND  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECN_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_ENQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_DIV  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_WAIT,
    S_DECIDE,
    S_WRITE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;       // latch input item
    logic div_step;   // one quotient bit
    logic scan_start; // reset scan
    logic scan_step;  // look at one entry
    logic decide;     // resolve operation
    logic commit;     // write memory and counters
    logic out_load;   // present result
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/core/pifo_ctrl.sv =====
// Controller state machine for the PIFO queue.
// Depends on pifo_pkg for states and command/status structs.
module pifo_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  pifo_pkg::stat_t stat,
  output logic           idle,
  output pifo_pkg::cmd_t cmd
);

  pifo_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pifo_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pifo_pkg::S_IDLE:   if (in_fire) state_next = pifo_pkg::S_DIV;
      pifo_pkg::S_DIV:    if (stat.div_done) state_next = pifo_pkg::S_SCAN;
      pifo_pkg::S_SCAN:   if (stat.scan_done) state_next = pifo_pkg::S_WAIT;
      pifo_pkg::S_WAIT:   state_next = pifo_pkg::S_DECIDE;
      pifo_pkg::S_DECIDE: state_next = pifo_pkg::S_WRITE;
      pifo_pkg::S_WRITE:  if (!stat.out_busy) state_next = pifo_pkg::S_OUT;
      pifo_pkg::S_OUT:    state_next = pifo_pkg::S_IDLE;
      default:            state_next = pifo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    unique case (state)
      pifo_pkg::S_IDLE: begin
        idle = 1'b1;
        cmd.load = in_fire;
      end
      pifo_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.scan_start = stat.div_done;
      end
      pifo_pkg::S_SCAN:   cmd.scan_step = 1'b1;
      pifo_pkg::S_WAIT:   cmd.scan_step = 1'b0;
      pifo_pkg::S_DECIDE: cmd.decide = 1'b1;
      pifo_pkg::S_WRITE:  cmd.commit = !stat.out_busy;
      pifo_pkg::S_OUT:    cmd.out_load = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/pifo_dp.sv =====
// Datapath of the PIFO queue: entry memories, valid bits, rank divider,
// entry scan with best/victim/oldest-tag trackers, output register. Uses pifo_pkg.
module pifo_dp #(
  parameter int DEPTH       = pifo_pkg::DEPTH_DEF,
  parameter int TAG_BITS    = pifo_pkg::TAG_BITS_DEF,
  parameter int MAX_RETRIES = pifo_pkg::MAX_RETRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pifo_pkg::cmd_t                    cmd,
  output pifo_pkg::stat_t                   stat,
  input  logic [1:0]                        in_op,
  input  logic [TAG_BITS-1:0]               in_tag,
  input  logic [pifo_pkg::RANK_W-1:0]       in_seq,
  input  logic [pifo_pkg::RC_W-1:0]         in_rc,
  input  logic                              in_tcp,
  input  logic                              cfg_we,
  input  logic [pifo_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pifo_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [TAG_BITS-1:0]               out_tag,
  output logic [pifo_pkg::RANK_W-1:0]       out_rank,
  output logic                              out_mark,
  output logic [pifo_pkg::OCC_W-1:0]        out_occ
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int RW   = pifo_pkg::RANK_W;
  localparam int SW   = pifo_pkg::STAMP_W;
  localparam int OW   = pifo_pkg::OCC_W;
  localparam int RCW  = $clog2(MAX_RETRIES + 1);
  localparam int BW   = $clog2(RW);
  localparam int ENT  = TAG_BITS + RW + SW + OW + 2;

  // config
  logic            drop_mode, serve_mode, mark_enq, boost_en;
  logic [7:0]      ecn_thr, boost_div;
  logic [OW-1:0]   capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_mode <= 1'b0; serve_mode <= 1'b0; ecn_thr <= 8'hFF; mark_enq <= 1'b1;
      boost_en <= 1'b0; boost_div <= 8'd0; capacity <= OW'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pifo_pkg::REG_DROP_MODE:  drop_mode  <= cfg_data[0];
        pifo_pkg::REG_SERVE_MODE: serve_mode <= cfg_data[0];
        pifo_pkg::REG_ECN_THR:    ecn_thr    <= cfg_data;
        pifo_pkg::REG_MARK_ENQ:   mark_enq   <= cfg_data[0];
        pifo_pkg::REG_BOOST_EN:   boost_en   <= cfg_data[0];
        pifo_pkg::REG_BOOST_DIV:  boost_div  <= cfg_data;
        pifo_pkg::REG_CAPACITY:   capacity   <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic thr_hit(input logic [7:0] thr, input logic [OW-1:0] occ);
    thr_hit = !thr[7] && ({2'b0, occ} >= {1'b0, thr});
  endfunction

  // latched item
  logic [1:0]          op;
  logic [TAG_BITS-1:0] tag;
  logic                tcp;
  logic [RCW-1:0]      divs_left;
  logic [RW-1:0]       rank, rem;
  logic [BW-1:0]       bitpos;
  logic                div_active;

  logic [RCW-1:0] rc_sat;
  assign rc_sat = (int'(in_rc) > MAX_RETRIES) ? RCW'(MAX_RETRIES) : RCW'(in_rc);

  // restoring divider, one quotient bit per cycle
  logic [RW:0]   trial;
  logic [RW-1:0] rem_sh;
  assign rem_sh = {rem[RW-2:0], rank[RW-1]};
  assign trial  = {1'b0, rem_sh} - {{(RW+1-8){1'b0}}, boost_div};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_op;
      tag <= in_tag;
      tcp <= in_tcp;
      rank <= in_seq;
      rem <= '0;
      bitpos <= '0;
      divs_left <= (in_op == pifo_pkg::OP_PUSH && boost_en && boost_div != 8'd0)
                   ? rc_sat : '0;
    end else if (cmd.div_step && divs_left != '0) begin
      rank <= {rank[RW-2:0], !trial[RW]};
      bitpos <= bitpos + 1'b1;
      if (bitpos == BW'(RW-1)) begin
        divs_left <= divs_left - 1'b1;
        rem <= '0;
      end else if (trial[RW]) begin
        rem <= rem_sh;
      end else begin
        rem <= trial[RW-1:0];
      end
    end
  end
  assign div_active = (divs_left != '0);
  assign stat.div_done = !div_active;

  // storage
  logic [ENT-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [SW-1:0]  arrival;
  logic [CW-1:0]  count;

  logic [CW:0]    scan_i;
  logic [IW-1:0]  rd_addr;
  logic [ENT-1:0] rd_data;
  logic           rd_ok, rd_ok_d;
  logic [IW-1:0]  rd_idx_d;

  assign rd_addr = scan_i[IW-1:0];
  assign rd_ok   = cmd.scan_step && (scan_i < (CW+1)'(DEPTH));
  assign stat.scan_done = cmd.scan_step && !(scan_i < (CW+1)'(DEPTH - 1));

  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [ENT-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok_d <= 1'b0;
    end else begin
      rd_ok_d <= rd_ok && valid[rd_addr];
    end
    rd_idx_d <= rd_addr;
    if (cmd.scan_start) scan_i <= '0;
    else if (rd_ok)     scan_i <= scan_i + 1'b1;
  end

  // unpack read entry
  logic [TAG_BITS-1:0] e_tag;
  logic [RW-1:0]       e_rank;
  logic [SW-1:0]       e_stamp, e_age;
  logic [OW-1:0]       e_occ;
  logic                e_tcp, e_mark;
  assign {e_tag, e_rank, e_stamp, e_occ, e_tcp, e_mark} = rd_data;
  assign e_age = arrival - e_stamp;

  // trackers: pop best, drop victim, remove hit, first free
  logic                b_v, v_v, h_v, f_v;
  logic [IW-1:0]       b_i, v_i, h_i, f_i;
  logic [RW-1:0]       b_rank, v_rank;
  logic [SW-1:0]       b_age, v_age, h_age;
  logic [TAG_BITS-1:0] b_tag, v_tag, h_tag;
  logic                b_mark, b_tcp, v_mark;
  logic [OW-1:0]       b_occ;
  logic [RW-1:0]       h_rank;

  logic take_b, take_v, take_h;
  always_comb begin
    if (serve_mode) take_b = !b_v || e_age > b_age;
    else take_b = !b_v || e_rank < b_rank || (e_rank == b_rank && e_age > b_age);
    take_v = !v_v || e_rank > v_rank || (e_rank == v_rank && e_age < v_age);
    take_h = (e_tag == tag) && (!h_v || e_age > h_age);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      b_v <= 1'b0; v_v <= 1'b0; h_v <= 1'b0; f_v <= 1'b0;
    end else begin
      if (rd_ok && !valid[rd_addr] && !f_v) begin
        f_v <= 1'b1; f_i <= rd_addr;
      end
      if (rd_ok_d) begin
        if (take_b) begin
          b_v <= 1'b1; b_i <= rd_idx_d; b_rank <= e_rank; b_age <= e_age;
          b_tag <= e_tag; b_mark <= e_mark; b_tcp <= e_tcp; b_occ <= e_occ;
        end
        if (take_v) begin
          v_v <= 1'b1; v_i <= rd_idx_d; v_rank <= e_rank; v_age <= e_age;
          v_tag <= e_tag; v_mark <= e_mark;
        end
        if (take_h) begin
          h_v <= 1'b1; h_i <= rd_idx_d; h_age <= e_age; h_tag <= e_tag; h_rank <= e_rank;
        end
      end
    end
  end

  // decision
  logic [2:0]          r_status, r_status_next;
  logic [TAG_BITS-1:0] r_tag, r_tag_next;
  logic [RW-1:0]       r_rank, r_rank_next;
  logic                r_mark, r_mark_next;
  logic                r_wr, r_clr, r_inc, r_dec, r_arr;
  logic                r_wr_next, r_clr_next, r_inc_next, r_dec_next, r_arr_next;
  logic [IW-1:0]       r_idx, r_idx_next;
  logic                push_mark;
  logic [CW:0]         eff_cap;

  always_comb begin
    if (capacity == '0) eff_cap = (CW+1)'(1);
    else if ({{(CW+1){1'b0}}, capacity} > (CW+1+OW)'(DEPTH)) eff_cap = (CW+1)'(DEPTH);
    else eff_cap = (CW+1)'(capacity);
  end
  assign push_mark = mark_enq && tcp && thr_hit(ecn_thr, OW'(count));

  always_comb begin
    r_wr_next = 1'b0; r_clr_next = 1'b0; r_inc_next = 1'b0; r_dec_next = 1'b0;
    r_arr_next = 1'b0;
    r_idx_next = f_i; r_mark_next = 1'b0; r_tag_next = '0; r_rank_next = '0;
    r_status_next = pifo_pkg::ST_NOTFND;
    unique case (op)
      pifo_pkg::OP_PUSH: begin
        r_arr_next = 1'b1;
        r_mark_next = push_mark; r_tag_next = tag; r_rank_next = rank;
        if ((({1'b0, count}) + 1'b1) <= eff_cap && f_v) begin
          r_status_next = pifo_pkg::ST_PUSHED; r_wr_next = 1'b1; r_inc_next = 1'b1;
        end else begin
          r_status_next = pifo_pkg::ST_DROPPED;
          if (!drop_mode && v_v && rank < v_rank) begin
            r_wr_next = 1'b1; r_idx_next = v_i;
            r_tag_next = v_tag; r_rank_next = v_rank; r_mark_next = v_mark;
          end
        end
      end
      pifo_pkg::OP_POP: begin
        if (b_v) begin
          r_status_next = pifo_pkg::ST_POPPED; r_clr_next = 1'b1; r_dec_next = 1'b1;
          r_idx_next = b_i;
          r_tag_next = b_tag; r_rank_next = b_rank;
          r_mark_next = b_mark || (!mark_enq && b_tcp && thr_hit(ecn_thr, b_occ));
        end else begin
          r_status_next = pifo_pkg::ST_EMPTY;
        end
      end
      pifo_pkg::OP_REMOVE: begin
        if (h_v) begin
          r_status_next = pifo_pkg::ST_REMOVED; r_clr_next = 1'b1; r_dec_next = 1'b1;
          r_idx_next = h_i;
          r_tag_next = h_tag; r_rank_next = h_rank;
        end else begin
          r_tag_next = tag;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      r_wr <= r_wr_next; r_clr <= r_clr_next; r_inc <= r_inc_next; r_dec <= r_dec_next;
      r_arr <= r_arr_next; r_idx <= r_idx_next; r_mark <= r_mark_next;
      r_tag <= r_tag_next; r_rank <= r_rank_next; r_status <= r_status_next;
    end
  end

  assign wr_en   = cmd.commit && r_wr;
  assign wr_addr = r_idx;
  assign wr_data = {tag, rank, arrival, OW'(count), tcp, push_mark};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; arrival <= '0; count <= '0;
    end else if (cmd.commit) begin
      if (r_wr)  valid[r_idx] <= 1'b1;
      if (r_clr) valid[r_idx] <= 1'b0;
      if (r_arr) arrival <= arrival + 1'b1;
      if (r_inc) count <= count + 1'b1;
      if (r_dec) count <= count - 1'b1;
    end
  end

  // output register
  assign stat.out_busy = out_valid && !out_ready;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      out_status <= r_status; out_tag <= r_tag; out_rank <= r_rank;
      out_mark <= r_mark; out_occ <= OW'(count);
    end
  end

endmodule

// ===== rtl/core/pifo_queue_priority_drop_unit.sv =====
// Channel  | Dir | Signals                     | Payload
// s_axis   | in  | s_axis_tvalid/tready/tdata  | operation, packet_tag, seq, retransmit_count, is_tcp
// m_axis   | out | m_axis_tvalid/tready/tdata  | status, tag, rank, ecn_marked, occupancy
// cfg      | in  | cfg_we, cfg_index, cfg_data | one register per write
// One item at a time. Push: when boosting is on, one rank division per retry (up to MAX_RETRIES),
// then a scan of the entry memory; without boosting, only the scan of the entry memory.
// The memory read port (one entry per cycle) sets the scan length.
// Synchronous reset clears valid bits, counters and config; the result waits in an
// output register while m_axis_tready is low; the next item is still taken, but its
// commit stalls until the waiting result transfers.
module pifo_queue_priority_drop_unit #(
  parameter int DEPTH       = pifo_pkg::DEPTH_DEF,
  parameter int TAG_BITS    = pifo_pkg::TAG_BITS_DEF,
  parameter int MAX_RETRIES = pifo_pkg::MAX_RETRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // operation, packet_tag, seq, retransmit_count, is_tcp
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // status, tag, rank, ecn_marked, occupancy
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  pifo_pkg::cmd_t  cmd;
  pifo_pkg::stat_t stat;
  logic            idle;

  logic [2:0]          o_status;
  logic [TAG_BITS-1:0] o_tag;
  logic [31:0]         o_rank;
  logic                o_mark;
  logic [6:0]          o_occ;

  assign s_axis_tready = idle;

  pifo_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .stat(stat), .idle(idle), .cmd(cmd)
  );

  pifo_dp #(.DEPTH(DEPTH), .TAG_BITS(TAG_BITS), .MAX_RETRIES(MAX_RETRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(s_axis_tdata[1:0]),
    .in_tag(TAG_BITS'(s_axis_tdata[17:2])),
    .in_seq(s_axis_tdata[49:18]),
    .in_rc(s_axis_tdata[53:50]),
    .in_tcp(s_axis_tdata[54]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(o_status), .out_tag(o_tag), .out_rank(o_rank),
    .out_mark(o_mark), .out_occ(o_occ)
  );

  assign m_axis_tdata = {5'd0, o_occ, o_mark, o_rank, 16'(o_tag), o_status};

endmodule

// ===== verif/tb_pifo_queue_priority_drop_unit.sv =====
// Self-checking testbench for pifo_queue_priority_drop_unit: stream stimulus, random
// backpressure and a scoreboard class that models the PIFO queue state per transfer.
// Depends on pifo_pkg and the DUT only.
`timescale 1ns / 1ps

module tb_pifo_queue_priority_drop_unit;

  localparam int QDEPTH = 64;
  localparam int MAXRC = 15;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic is_tcp;
    logic [3:0] rc;
    logic [31:0] seq;
    logic [15:0] tag;
    logic [1:0] op;
  } op_item_t;

  typedef struct packed {
    logic [6:0] occ;
    logic mark;
    logic [31:0] rank;
    logic [15:0] tag;
    logic [2:0] status;
  } queue_result_t;

  class pifo_scoreboard;
    logic drop_newest, serve_fifo, mark_enq, boost_on;
    logic signed [7:0] ecn_thr;
    logic [7:0] divisor;
    logic [6:0] cap;
    bit valid[QDEPTH];
    logic [15:0] e_tag[QDEPTH];
    logic [31:0] e_rank[QDEPTH];
    logic [31:0] e_stamp[QDEPTH];
    logic [6:0] e_occ[QDEPTH];
    bit e_tcp[QDEPTH];
    bit e_mark[QDEPTH];
    logic [31:0] arrivals;
    int count;
    int errors;
    queue_result_t expected_q[$];

    function new();
      drop_newest = 0; serve_fifo = 0; mark_enq = 1; boost_on = 0;
      ecn_thr = -1; divisor = 0; cap = 64;
      foreach (valid[i]) valid[i] = 0;
      arrivals = 0; count = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        pifo_pkg::REG_DROP_MODE: drop_newest = val[0];
        pifo_pkg::REG_SERVE_MODE: serve_fifo = val[0];
        pifo_pkg::REG_ECN_THR: ecn_thr = val;
        pifo_pkg::REG_MARK_ENQ: mark_enq = val[0];
        pifo_pkg::REG_BOOST_EN: boost_on = val[0];
        pifo_pkg::REG_BOOST_DIV: divisor = val;
        pifo_pkg::REG_CAPACITY: cap = val[6:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] age(int i);
      return arrivals - e_stamp[i];
    endfunction

    function bit over_thr(logic [6:0] occ);
      return ecn_thr >= 0 && {1'b0, occ} >= ecn_thr;
    endfunction

    function logic [31:0] boosted_rank(logic [31:0] seq, logic [3:0] rc);
      logic [31:0] r;
      r = seq;
      if (boost_on && divisor != 0)
        for (int k = 0; k < ((rc > MAXRC) ? MAXRC : rc); k++) r = r / divisor;
      return r;
    endfunction

    function void put_entry(int i, op_item_t it, logic [31:0] rk, int occ, bit mk);
      valid[i] = 1; e_tag[i] = it.tag; e_rank[i] = rk; e_stamp[i] = arrivals;
      e_occ[i] = 7'(occ); e_tcp[i] = it.is_tcp; e_mark[i] = mk;
    endfunction

    function logic [15:0] pick_tag();
      int idx[$];
      foreach (valid[i]) if (valid[i]) idx.insert(idx.size(), i);
      if (idx.size() == 0) return 16'($urandom_range(0, 15));
      return e_tag[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    function void note_item(op_item_t it);
      queue_result_t r;
      logic [31:0] rk;
      int occ, slot, pick, effcap;
      bit mk;
      r = '0;
      pick = -1;
      case (it.op)
        pifo_pkg::OP_PUSH: begin
          rk = boosted_rank(it.seq, it.rc);
          occ = count;
          mk = mark_enq && it.is_tcp && over_thr(7'(occ));
          effcap = (cap < 1) ? 1 : (cap > QDEPTH) ? QDEPTH : cap;
          slot = -1;
          if (count + 1 <= effcap)
            for (int i = 0; i < QDEPTH; i++) if (!valid[i] && slot < 0) slot = i;
          if (slot >= 0) begin
            put_entry(slot, it, rk, occ, mk);
            arrivals++;
            count++;
            r.status = pifo_pkg::ST_PUSHED; r.tag = it.tag; r.rank = rk; r.mark = mk;
          end else begin
            if (!drop_newest)
              for (int i = 0; i < QDEPTH; i++)
                if (valid[i] && (pick < 0 || e_rank[i] > e_rank[pick] ||
                    (e_rank[i] == e_rank[pick] && age(i) < age(pick))))
                  pick = i;
            r.status = pifo_pkg::ST_DROPPED;
            if (pick < 0 || rk >= e_rank[pick]) begin
              r.tag = it.tag; r.rank = rk; r.mark = mk;
            end else begin
              r.tag = e_tag[pick]; r.rank = e_rank[pick]; r.mark = e_mark[pick];
              put_entry(pick, it, rk, occ, mk);
            end
            arrivals++;
          end
        end
        pifo_pkg::OP_POP: begin
          for (int i = 0; i < QDEPTH; i++) begin
            if (!valid[i]) continue;
            if (pick < 0) pick = i;
            else if (serve_fifo) begin
              if (age(i) > age(pick)) pick = i;
            end else if (e_rank[i] < e_rank[pick] ||
                         (e_rank[i] == e_rank[pick] && age(i) > age(pick))) begin
              pick = i;
            end
          end
          if (pick < 0) r.status = pifo_pkg::ST_EMPTY;
          else begin
            r.status = pifo_pkg::ST_POPPED; r.tag = e_tag[pick]; r.rank = e_rank[pick];
            r.mark = e_mark[pick] || (!mark_enq && e_tcp[pick] && over_thr(e_occ[pick]));
            valid[pick] = 0;
            count--;
          end
        end
        pifo_pkg::OP_REMOVE: begin
          for (int i = 0; i < QDEPTH; i++)
            if (valid[i] && e_tag[i] == it.tag && (pick < 0 || age(i) > age(pick)))
              pick = i;
          if (pick < 0) begin
            r.status = pifo_pkg::ST_NOTFND; r.tag = it.tag;
          end else begin
            r.status = pifo_pkg::ST_REMOVED; r.tag = e_tag[pick]; r.rank = e_rank[pick];
            valid[pick] = 0;
            count--;
          end
        end
        default: r.status = pifo_pkg::ST_NOTFND;
      endcase
      r.occ = 7'(count);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [63:0] d);
      queue_result_t e, a;
      a = d[58:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status); errors++;
      end
      if (a.tag !== e.tag) begin
        $display("%0t: tag exp %h got %h", $time, e.tag, a.tag); errors++;
      end
      if (a.rank !== e.rank) begin
        $display("%0t: rank exp %h got %h", $time, e.rank, a.rank); errors++;
      end
      if (a.mark !== e.mark) begin
        $display("%0t: ecn exp %0b got %0b", $time, e.mark, a.mark); errors++;
      end
      if (a.occ !== e.occ) begin
        $display("%0t: occupancy exp %0d got %0d", $time, e.occ, a.occ); errors++;
      end
      if (d[63:59] !== 5'd0) begin
        $display("%0t: pad exp 0 got %h", $time, d[63:59]); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, cfg_we;
  logic [55:0] s_axis_tdata;
  logic [63:0] m_axis_tdata;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  pifo_scoreboard sb = new();
  bit tx_steady, rx_steady, hold_once;
  longint cycles = 0;

  pifo_queue_priority_drop_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function op_item_t mk(logic [1:0] op, logic [15:0] tag, logic [31:0] seq,
                        logic [3:0] rc, logic tcp);
    op_item_t it;
    it.op = op; it.tag = tag; it.seq = seq; it.rc = rc; it.is_tcp = tcp;
    return it;
  endfunction

  function op_item_t rand_item(int push_pct);
    op_item_t it;
    int r;
    it.tag = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    it.seq = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20) : $urandom;
    it.rc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, 3));
    it.is_tcp = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < push_pct) it.op = pifo_pkg::OP_PUSH;
    else begin
      r = $urandom_range(0, 9);
      it.op = (r < 6) ? pifo_pkg::OP_POP : (r < 9) ? pifo_pkg::OP_REMOVE
                                                   : pifo_pkg::OP_UNUSED;
      if (it.op == pifo_pkg::OP_REMOVE && $urandom_range(0, 9) < 7) it.tag = sb.pick_tag();
    end
    return it;
  endfunction

  // tvalid is left high after a transfer; the next call or the phase end decides
  task send(op_item_t it);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, it};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  task configure(logic dm, logic sm, logic [7:0] thr, logic me, logic be,
                 logic [7:0] dv, logic [7:0] cp);
    logic [7:0] vals[7];
    vals = '{{7'd0, dm}, {7'd0, sm}, thr, {7'd0, me}, {7'd0, be}, dv, cp};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(3'(i), vals[i]);
    end
    cfg_we <= 0;
  endtask

  task drain();
    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task run_random(int n, int push_pct);
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) send(rand_item(push_pct));
    drain();
  endtask

  initial begin
    int gap;
    m_axis_tready <= 0;
    wait (rst === 1'b0);
    forever begin
      if (hold_once) begin
        hold_once = 0;
        m_axis_tready <= 0;
        repeat (500) @(posedge clk);
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          m_axis_tready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata <= '0;
    cfg_we <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: capacity 3, boost by 2, mark from occupancy 1
    configure(0, 0, 8'd1, 1, 1, 8'd2, 8'd3);
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    send(mk(pifo_pkg::OP_REMOVE, 16'h1234, 0, 0, 0));
    send(mk(pifo_pkg::OP_UNUSED, 16'hffff, 32'hffffffff, 4'hf, 1));
    send(mk(pifo_pkg::OP_PUSH, 16'h0000, 32'h0, 0, 1));
    send(mk(pifo_pkg::OP_PUSH, 16'hffff, 32'hffffffff, 4'hf, 1));
    send(mk(pifo_pkg::OP_PUSH, 16'h0005, 32'd800, 4'd3, 1));
    send(mk(pifo_pkg::OP_PUSH, 16'h0006, 32'd7, 0, 0));
    send(mk(pifo_pkg::OP_PUSH, 16'h0007, 32'hfffffff0, 0, 1));
    send(mk(pifo_pkg::OP_PUSH, 16'h0005, 32'd100, 4'd1, 0));
    send(mk(pifo_pkg::OP_REMOVE, 16'h0005, 0, 0, 0));
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    drain();

    // divisor 1, dequeue marking from zero
    configure(0, 0, 8'd0, 0, 1, 8'd1, 8'd8);
    send(mk(pifo_pkg::OP_PUSH, 16'h0011, 32'd50, 4'd9, 1));
    send(mk(pifo_pkg::OP_PUSH, 16'h0012, 32'd50, 4'd2, 0));
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    send(mk(pifo_pkg::OP_POP, 0, 0, 0, 0));
    drain();
    run_random(100, 55);

    configure(1, 1, 8'hff, 0, 0, 8'd0, 8'd64);
    hold_once = 1;
    run_random(110, 80);
    configure(1, 0, 8'd64, 1, 1, 8'd255, 8'd0);
    run_random(90, 50);
    configure(0, 1, 8'd5, 0, 1, 8'd3, 8'd100);
    run_random(110, 65);
    configure(0, 0, 8'h80, 1, 1, 8'd7, 8'd1);
    run_random(80, 50);
    configure(0, 0, 8'd2, 1, 0, 8'd5, 8'd20);
    run_random(110, 60);
    configure(1, 0, 8'd3, 0, 1, 8'd2, 8'd6);
    run_random(80, 55);

    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
